/* rtl/core/liu_pkg.sv */
package liu_pkg;

    // Block configuration
    localparam int MODULES = 8;
    localparam int FACTOR  = 6;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int MODREQ_W = 3;
    localparam int IDX_W    = (MODULES > 1) ? $clog2(MODULES) : 1;
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int K_W      = $clog2(FACTOR + 1);

    // Interpolation numerator FACTOR*prev + k*diff, |num| <= FACTOR * 2^15
    localparam int NUM_W    = SAMPLE_W + $clog2(FACTOR) + 1;
    localparam int MAG_W    = NUM_W;

    // Reciprocal of FACTOR, rounded up; the extra bits keep the error below 1/FACTOR
    localparam int      RECIP_SH = MAG_W + $clog2(FACTOR) + 2;
    localparam longint  RECIP    = (longint'(1) << RECIP_SH) / FACTOR + 1;
    localparam int      RECIP_W  = $clog2(RECIP + 1);
    localparam int      PROD_W   = MAG_W + RECIP_W;

    // Queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [MODREQ_W-1:0]        module_req;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       silence;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       last;
    } out_t;

    // One interpolation job: start point and step
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] prev;
        logic signed [DIFF_W-1:0]   diff;
    } job_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

endpackage

/* rtl/core/liu_front.sv */
module liu_front
    import liu_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  in_t       s_data,
    input  logic      s_valid,
    output logic      s_ready,
    input  q_status_t q_status,
    output logic      push,
    output job_t      push_job
);

    logic signed [SAMPLE_W-1:0] prev_reg [MODULES];
    logic                       accept;
    logic                       mod_ok;
    logic [IDX_W-1:0]           idx;
    logic signed [SAMPLE_W-1:0] prev_cur;

    assign s_ready  = !q_status.full;
    assign accept   = s_valid && s_ready;
    assign mod_ok   = int'(s_data.module_req) < MODULES;
    assign idx      = s_data.module_req[IDX_W-1:0];
    assign prev_cur = mod_ok ? prev_reg[idx] : '0;

    assign push          = accept && mod_ok && !s_data.silence;
    assign push_job.prev = prev_cur;
    assign push_job.diff = DIFF_W'(s_data.sample) - DIFF_W'(prev_cur);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MODULES; i++) begin
                prev_reg[i] <= '0;
            end
        end else if (accept && mod_ok) begin
            prev_reg[idx] <= s_data.silence ? '0 : s_data.sample;
        end
    end

endmodule

/* rtl/core/liu_queue.sv */
module liu_queue
    import liu_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  job_t      push_job,
    input  logic      pop,
    output job_t      head_job,
    output q_status_t q_status,
    output logic [QCNT_W-1:0] count
);

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign q_status.valid = count_reg != '0;
    assign q_status.full  = count_reg == QCNT_W'(QDEPTH);
    assign head_job       = mem_reg[rd_ptr_reg];
    assign count          = count_reg;

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* rtl/core/liu_back.sv */
module liu_back
    import liu_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  job_t      head_job,
    input  q_status_t q_status,
    output logic      pop,
    output out_t      m_data,
    output logic      m_valid,
    input  logic      m_ready
);

    localparam logic signed [NUM_W-1:0] FAC_S  = NUM_W'(FACTOR);
    localparam logic [RECIP_W-1:0]      RECIP_C = RECIP_W'(RECIP);

    // Frame sequencer
    logic                     busy_reg, busy_next;
    logic [K_W-1:0]           k_reg, k_next;
    logic signed [NUM_W-1:0]  num_reg, num_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;

    // Stage 1: magnitude and sign of the numerator
    logic             s1_valid_reg;
    logic [MAG_W-1:0] s1_mag_reg;
    logic             s1_neg_reg;
    logic             s1_last_reg;

    // Output register
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_val_reg;
    logic                       out_last_reg;

    logic                       advance;
    logic                       gen_valid;
    logic [K_W-1:0]             k_cur;
    logic signed [NUM_W-1:0]    base;
    logic signed [DIFF_W-1:0]   step;
    logic signed [NUM_W-1:0]    num;
    logic                       gen_last;
    logic [PROD_W-1:0]          prod;
    logic [SAMPLE_W-1:0]        quot;
    logic signed [SAMPLE_W-1:0] val;

    assign advance   = !out_valid_reg || m_ready;
    assign gen_valid = busy_reg || q_status.valid;
    assign pop       = advance && !busy_reg && q_status.valid;

    always_comb begin
        k_cur    = busy_reg ? k_reg : K_W'(1);
        base     = busy_reg ? num_reg : NUM_W'(head_job.prev) * FAC_S;
        step     = busy_reg ? diff_reg : head_job.diff;
        num      = base + NUM_W'(step);
        gen_last = k_cur == K_W'(FACTOR);

        busy_next = busy_reg;
        k_next    = k_reg;
        num_next  = num_reg;
        diff_next = diff_reg;
        if (advance && gen_valid) begin
            busy_next = !gen_last;
            k_next    = k_cur + 1'b1;
            num_next  = num;
            diff_next = step;
        end
    end

    // Truncating divide by FACTOR: reciprocal multiply on the magnitude
    assign prod = PROD_W'(s1_mag_reg) * PROD_W'(RECIP_C);
    assign quot = prod[RECIP_SH +: SAMPLE_W];
    assign val  = s1_neg_reg ? -$signed(quot) : $signed(quot);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            if (advance) begin
                s1_valid_reg  <= gen_valid;
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        k_reg    <= k_next;
        num_reg  <= num_next;
        diff_reg <= diff_next;
        if (advance) begin
            s1_neg_reg   <= num[NUM_W-1];
            s1_mag_reg   <= num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
            s1_last_reg  <= gen_last;
            out_val_reg  <= val;
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_data.left  = out_val_reg;
    assign m_data.right = out_val_reg;
    assign m_data.last  = out_last_reg;

endmodule

/* rtl/core/linear_interp_upsampler_mono_to_stereo_top.sv */
// Mono-to-stereo linear interpolation upsampler, factor FACTOR (6). Each input
// transfer carries a 16-bit mono sample and a source module index; every module
// keeps its own last sample. A normal sample produces FACTOR stereo frames that
// step exactly from the stored sample to the new one, frame k being
// trunc((FACTOR*prev + k*(cur-prev)) / FACTOR), left equal to right, the final
// frame flagged with last. A silence transfer zeroes that module's stored
// sample and produces no frames; an index at or above MODULES is dropped.
// Rate: one frame per cycle from the output sequencer while m_ready does not
// stall it, and samples stream back to back at that pace. A two-entry job
// queue decouples input and output, so input keeps flowing while the output
// side stalls until the queue fills.
module linear_interp_upsampler_mono_to_stereo_top
    import liu_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    // Sample input
    input  in_t  s_data,
    input  logic s_valid,
    output logic s_ready,
    // Frame output
    output out_t m_data,
    output logic m_valid,
    input  logic m_ready
);

    q_status_t         q_status;
    logic              push;
    logic              pop;
    job_t              push_job;
    job_t              head_job;
    logic [QCNT_W-1:0] q_count;

    // Front: per-module sample store, builds one job per normal transfer
    liu_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_data   (s_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    // Job queue
    liu_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_status (q_status),
        .count    (q_count)
    );

    // Back: frame sequencer, divide pipeline and output register
    liu_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .q_status (q_status),
        .pop      (pop),
        .m_data   (m_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready)
    );

`ifndef NO_ASSERTIONS
    // Both channels of a frame carry the same value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.left == m_data.right)
        else $error("left and right differ");

    // Queue never overfills and never pops empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= QCNT_W'(QDEPTH) && !(pop && q_count == '0))
        else $error("job queue over or underflow");

    // Silence transfers never create a job
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.silence) |-> !push)
        else $error("silence transfer queued a job");

    // No frame comes out on the first edge after reset is released
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_valid)
        else $error("output valid after reset");
`endif

endmodule

/* test/tb_linear_interp_upsampler_mono_to_stereo_top.sv */
module tb_linear_interp_upsampler_mono_to_stereo_top
    import liu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Silence flag values on the input transfer
    localparam logic SILENT  = 1'b1;
    localparam logic AUDIBLE = 1'b0;

    localparam int RAND_ITEMS  = 260;
    localparam int CALM_ITEMS  = 40;   // tail of the random part runs with no idling
    localparam int PAUSE_AT    = 140;  // sender holds off here until all frames are out
    localparam int TAIL_CYCLES = 20;   // margin after the last expected frame, for stray frames
    // Worst legal gap between transfers: the longest sender gap or receiver stall,
    // plus the pipeline. Allow many times that.
    localparam int STALL_LIMIT = 1000;

    logic aclk;
    logic aresetn = 1'b0;
    in_t  s_data  = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    out_t m_data;
    logic m_valid;
    logic m_ready = 1'b0;

    linear_interp_upsampler_mono_to_stereo_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Predictor state: last sample per source module, zero out of reset
    logic signed [SAMPLE_W-1:0] held_sample [MODULES];
    out_t pending_frames [$];

    int err_count   = 0;
    int idle_cycles = 0;
    int stall_left  = 0;
    bit calm        = 1'b0;

    // Directed rows. typed = 1 means every frame of the row is known by eye
    // (flat line at 'level'); those rows are checked against the typed value.
    typedef struct {
        in_t item;
        bit  typed;
        int  level;
    } dir_row_t;

    dir_row_t dir_rows [19] = '{
        '{'{3'd0, 16'h0000, AUDIBLE}, 1'b1, 0},       // zero after reset
        '{'{3'd1, 16'h7FFF, AUDIBLE}, 1'b0, 0},       // ramp from 0 to max
        '{'{3'd1, 16'h7FFF, AUDIBLE}, 1'b1, 32767},   // flat at max
        '{'{3'd1, 16'h8000, AUDIBLE}, 1'b0, 0},       // full-scale swing down
        '{'{3'd1, 16'h8000, AUDIBLE}, 1'b1, -32768},  // flat at min
        '{'{3'd1, 16'h7FFF, AUDIBLE}, 1'b0, 0},       // full-scale swing up
        '{'{3'd1, 16'h1234, SILENT},  1'b0, 0},       // silence, sample ignored
        '{'{3'd1, 16'h0000, AUDIBLE}, 1'b1, 0},       // silence cleared the history
        '{'{3'd7, 16'hFFFF, AUDIBLE}, 1'b0, 0},       // truncation toward zero, negative
        '{'{3'd7, 16'h0005, AUDIBLE}, 1'b0, 0},
        '{'{3'd2, 16'h8000, AUDIBLE}, 1'b0, 0},
        '{'{3'd3, 16'h0007, AUDIBLE}, 1'b0, 0},       // truncation, positive
        '{'{3'd2, 16'h8000, SILENT},  1'b0, 0},
        '{'{3'd2, 16'h0000, AUDIBLE}, 1'b1, 0},
        '{'{3'd4, 16'h7FFF, SILENT},  1'b0, 0},       // silence on an untouched module
        '{'{3'd5, 16'hFFF9, AUDIBLE}, 1'b0, 0},
        '{'{3'd6, 16'h0001, AUDIBLE}, 1'b0, 0},
        '{'{3'd6, 16'h0001, AUDIBLE}, 1'b1, 1},       // equal samples
        '{'{3'd0, 16'h7FFF, AUDIBLE}, 1'b0, 0}        // module 0 untouched by the others
    };

    task automatic log_mismatch(input string what);
        err_count++;
        // keep the log bounded if the block is badly broken
        if (err_count <= 100) begin
            $display("MISMATCH @%0t: %s", $realtime, what);
        end
    endtask

    // Update the per-module history for one accepted transfer and queue the
    // frames it should produce.
    function automatic void note_sample(input in_t item, input bit typed, input int level);
        int   prior;
        int   cur;
        int   num;
        out_t f;
        if (item.module_req >= MODULES) begin
            return;
        end
        if (item.silence == SILENT) begin
            held_sample[item.module_req] = '0;
            return;
        end
        prior = int'(held_sample[item.module_req]);
        cur   = int'($signed(item.sample));
        for (int k = 1; k <= FACTOR; k++) begin
            // SV integer division truncates toward zero, as required
            num     = FACTOR * prior + k * (cur - prior);
            f.left  = typed ? SAMPLE_W'(level) : SAMPLE_W'(num / FACTOR);
            f.right = f.left;
            f.last  = (k == FACTOR);
            pending_frames.push_back(f);
        end
        held_sample[item.module_req] = item.sample;
    endfunction

    // Random item: mostly audio, some silence; sample values lean toward the
    // extremes, small values (truncation) and repeats of the held sample.
    function automatic in_t rand_sample();
        in_t item;
        int  pick;
        item.module_req = MODREQ_W'($urandom_range(0, MODULES - 1));
        item.silence    = ($urandom_range(0, 9) == 0) ? SILENT : AUDIBLE;
        pick            = $urandom_range(0, 99);
        if (pick < 20) begin
            case ($urandom_range(0, 4))
                0: item.sample = 16'h8000;
                1: item.sample = 16'h7FFF;
                2: item.sample = 16'h0000;
                3: item.sample = 16'hFFFF;
                default: item.sample = 16'h0001;
            endcase
        end else if (pick < 45) begin
            item.sample = SAMPLE_W'($signed($urandom_range(0, 48)) - 24);
        end else if (pick < 55) begin
            item.sample = held_sample[item.module_req];
        end else begin
            item.sample = SAMPLE_W'($urandom);
        end
        return item;
    endfunction

    // Present one item and hold it until the transfer happens
    task automatic send_sample(input in_t item, input bit typed, input int level);
        s_data  <= item;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        note_sample(item, typed, level);
    endtask

    // Random sender gap after a transfer
    task automatic sender_rest();
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    // Hold off the sender until every queued frame has come out
    task automatic drain_frames();
        s_valid <= 1'b0;
        while (pending_frames.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic check_frame(input out_t got);
        out_t  want;
        string bad;
        if (pending_frames.size() == 0) begin
            log_mismatch($sformatf("frame L=%0d R=%0d last=%0b with none expected",
                                   got.left, got.right, got.last));
            return;
        end
        want = pending_frames.pop_front();
        bad  = "";
        if (got.left !== want.left) begin
            bad = {bad, $sformatf(" left %0d/%0d", got.left, want.left)};
        end
        if (got.right !== want.right) begin
            bad = {bad, $sformatf(" right %0d/%0d", got.right, want.right)};
        end
        if (got.last !== want.last) begin
            bad = {bad, $sformatf(" last %0b/%0b", got.last, want.last)};
        end
        if (bad != "") begin
            log_mismatch({"frame field got/want:", bad});
        end
    endtask

    // Frame side: check each transfer, then decide m_ready for the next cycle.
    // Stalls come in bursts; the calm tail keeps ready high throughout.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            check_frame(m_data);
        end
        if (calm) begin
            m_ready    <= 1'b1;
            stall_left = 0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 6) == 0) begin
            m_ready    <= 1'b0;
            stall_left = $urandom_range(0, 15);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: too many cycles without a transfer on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("TIMEOUT: no transfer for %0d cycles", STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        foreach (held_sample[i]) begin
            held_sample[i] = '0;
        end

        // Synchronous reset, once
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table
        foreach (dir_rows[i]) begin
            send_sample(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].level);
            sender_rest();
        end
        drain_frames();

        // Random part; the last stretch runs with no idling on either side
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS - CALM_ITEMS) begin
                calm = 1'b1;
            end
            send_sample(rand_sample(), 1'b0, 0);
            sender_rest();
            if (n == PAUSE_AT) begin
                drain_frames();
            end
        end
        s_valid <= 1'b0;

        // Wait out the expected frames, then a short tail for strays
        while (pending_frames.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
